// ===== rtl/core/sha256he_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256he_pkg
// Shared types, constants and helper functions of the SHA-256 hash engine.
// ----------------------------------------------------------------------------
package sha256he_pkg;

  localparam int WORD_W    = 32;
  localparam int BLK_WORDS = 16;
  localparam int BLK_AW    = $clog2(BLK_WORDS);
  localparam int ROUNDS    = 64;
  localparam int DIG_WORDS = 8;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [DIG_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Working variables of the compression loop.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] f;
    logic [31:0] g;
    logic [31:0] h;
  } work_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PAD    = 7'b0000010,
    ST_ZERO   = 7'b0000100,
    ST_LEN_HI = 7'b0001000,
    ST_LEN_LO = 7'b0010000,
    ST_COMP   = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  // Where to go once a compression finishes.
  typedef enum logic [1:0] {
    AC_IDLE = 2'd0,
    AC_PAD  = 2'd1,
    AC_ZERO = 2'd2,
    AC_OUT  = 2'd3
  } after_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
    ror32 = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] v);
    big_sig0 = ror32(v, 2) ^ ror32(v, 13) ^ ror32(v, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] v);
    big_sig1 = ror32(v, 6) ^ ror32(v, 11) ^ ror32(v, 25);
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] v);
    sml_sig0 = ror32(v, 7) ^ ror32(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] v);
    sml_sig1 = ror32(v, 17) ^ ror32(v, 19) ^ (v >> 10);
  endfunction

endpackage

// ===== rtl/core/sha256he_ram.sv =====
// ----------------------------------------------------------------------------
// sha256he_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sha256he_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sha256he_round.sv =====
// ----------------------------------------------------------------------------
// sha256he_round
// One SHA-256 compression round on the working variables.
// ----------------------------------------------------------------------------
module sha256he_round import sha256he_pkg::*; (
  input  work_t       cur,
  input  logic [31:0] k,
  input  logic [31:0] w,
  output work_t       nxt
);

  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    ch  = (cur.e & cur.f) ^ (~cur.e & cur.g);
    maj = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
    t1  = cur.h + big_sig1(cur.e) + ch + k + w;
    t2  = big_sig0(cur.a) + maj;
    nxt.h = cur.g;
    nxt.g = cur.f;
    nxt.f = cur.e;
    nxt.e = cur.d + t1;
    nxt.d = cur.c;
    nxt.c = cur.b;
    nxt.b = cur.a;
    nxt.a = t1 + t2;
  end

endmodule

// ===== rtl/core/sha256_hash_engine.sv =====
// ----------------------------------------------------------------------------
// sha256_hash_engine
// Streaming SHA-256: bytes in, eight digest words out per message.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while a block fills; a full block stalls the
//   input for its compression (one round per cycle), so sustained input is
//   limited by the single shared round unit.
// After last: padding and length writes, one or two compressions, then eight
//   digest beats, one per cycle without stall.
// Reset: synchronous; hash words return to the initial values, bit count to 0.
// ----------------------------------------------------------------------------
module sha256_hash_engine import sha256he_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        last,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  localparam int CNT_W = $clog2(ROUNDS + 2);
  localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(ROUNDS + 1);
  localparam logic [BLK_AW:0]  LEN_HI_ADDR = (BLK_AW + 1)'(BLK_WORDS - 2);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t              state;
  after_t              after;
  logic [31:0]         hash_words [DIG_WORDS];
  logic [63:0]         bit_count;
  logic [23:0]         acc;         // last three bytes of a partial word
  logic [BLK_AW:0]     waddr;       // padding write pointer, can reach 16
  logic                need_two;    // padding spills into a second block
  logic [CNT_W-1:0]    cnt;         // compression step
  logic [2:0]          oidx;        // digest beat index
  work_t               work;
  logic [31:0]         w_sr [BLK_WORDS];

  // --------------------------------------------------------------------------
  // Block buffer memory: sixteen big-endian 32-bit words
  // --------------------------------------------------------------------------
  logic              ram_we;
  logic [BLK_AW-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [BLK_AW-1:0] ram_raddr;
  logic [31:0]       ram_rdata;

  sha256he_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BLK_WORDS)
  ) u_blk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic in_fire;
  logic out_fire;
  logic blk_full;    // the accepted byte is the 64th of its block

  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (state == ST_OUT);
  assign out_fire  = out_valid && !out_stall;
  assign blk_full  = byte_present && (bit_count[8:3] == 6'h3f);

  // Digest beats come straight from the hash registers, which hold still
  // while the OUT state waits on a stall.
  assign digest_word = hash_words[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd7);

  // --------------------------------------------------------------------------
  // Padding word: message bytes already gathered, then 0x80, then zeros
  // --------------------------------------------------------------------------
  logic [31:0] pad_word;

  always_comb begin
    case (bit_count[4:3])
      2'd0:    pad_word = {PAD_BYTE, 24'h0};
      2'd1:    pad_word = {acc[7:0], PAD_BYTE, 16'h0};
      2'd2:    pad_word = {acc[15:0], PAD_BYTE, 8'h0};
      2'd3:    pad_word = {acc[23:0], PAD_BYTE};
      default: pad_word = {PAD_BYTE, 24'h0};
    endcase
  end

  // --------------------------------------------------------------------------
  // Block buffer write port
  // --------------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bit_count[8:5];
    ram_wdata = {acc, data_byte};
    case (state)
      ST_IDLE: begin
        // store a word once its fourth byte arrives
        ram_we = in_fire && byte_present && (bit_count[4:3] == 2'd3);
      end
      ST_PAD: begin
        ram_we    = 1'b1;
        ram_wdata = pad_word;
      end
      ST_ZERO: begin
        ram_waddr = waddr[BLK_AW-1:0];
        ram_wdata = '0;
        ram_we    = need_two ? !waddr[BLK_AW] : (waddr != LEN_HI_ADDR);
      end
      ST_LEN_HI: begin
        ram_we    = 1'b1;
        ram_waddr = BLK_AW'(BLK_WORDS - 2);
        ram_wdata = bit_count[63:32];
      end
      ST_LEN_LO: begin
        ram_we    = 1'b1;
        ram_waddr = BLK_AW'(BLK_WORDS - 1);
        ram_wdata = bit_count[31:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Read word r in step r, so it lands for round r in step r + 1.
  assign ram_raddr = cnt[BLK_AW-1:0];

  // --------------------------------------------------------------------------
  // Message schedule and round datapath
  // --------------------------------------------------------------------------
  logic [5:0]  rnd;
  logic [31:0] sched;
  logic [31:0] wt;
  work_t       work_next;

  assign rnd   = 6'(cnt - CNT_W'(1));
  assign sched = sml_sig1(w_sr[BLK_WORDS-2]) + w_sr[BLK_WORDS-7]
               + sml_sig0(w_sr[1]) + w_sr[0];
  assign wt    = (rnd < 6'(BLK_WORDS)) ? ram_rdata : sched;

  sha256he_round u_round (
    .cur (work),
    .k   (ROUND_K[rnd]),
    .w   (wt),
    .nxt (work_next)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      after     <= AC_IDLE;
      bit_count <= '0;
      waddr     <= '0;
      need_two  <= 1'b0;
      cnt       <= '0;
      oidx      <= '0;
      for (int i = 0; i < DIG_WORDS; i++) begin
        hash_words[i] <= INIT_HASH[i];
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (byte_present) begin
              acc       <= {acc[15:0], data_byte};
              bit_count <= bit_count + 64'd8;
            end
            // a full block compresses before any padding
            if (blk_full) begin
              state <= ST_COMP;
              after <= last ? AC_PAD : AC_IDLE;
            end else if (last) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          waddr    <= {1'b0, bit_count[8:5]} + (BLK_AW + 1)'(1);
          need_two <= (bit_count[8:6] == 3'b111);
          state    <= ST_ZERO;
        end
        ST_ZERO: begin
          if (need_two) begin
            if (waddr[BLK_AW]) begin
              // first block closed, continue with zeros in a fresh one
              need_two <= 1'b0;
              waddr    <= '0;
              state    <= ST_COMP;
              after    <= AC_ZERO;
            end else begin
              waddr <= waddr + (BLK_AW + 1)'(1);
            end
          end else if (waddr == LEN_HI_ADDR) begin
            state <= ST_LEN_HI;
          end else begin
            waddr <= waddr + (BLK_AW + 1)'(1);
          end
        end
        ST_LEN_HI: begin
          state <= ST_LEN_LO;
        end
        ST_LEN_LO: begin
          state <= ST_COMP;
          after <= AC_OUT;
        end
        ST_COMP: begin
          if (cnt == CNT_DONE) begin
            cnt <= '0;
            for (int i = 0; i < DIG_WORDS; i++) begin
              hash_words[i] <= hash_words[i] + work[(DIG_WORDS-1-i)*32 +: 32];
            end
            case (after)
              AC_IDLE: state <= ST_IDLE;
              AC_PAD:  state <= ST_PAD;
              AC_ZERO: state <= ST_ZERO;
              AC_OUT:  state <= ST_OUT;
              default: state <= ST_IDLE;
            endcase
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_OUT: begin
          if (out_fire) begin
            oidx <= oidx + 3'd1;
            if (last_word) begin
              // ready for the next message
              state     <= ST_IDLE;
              bit_count <= '0;
              for (int i = 0; i < DIG_WORDS; i++) begin
                hash_words[i] <= INIT_HASH[i];
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Working variables and schedule window: payload, no reset.
  always_ff @(posedge clk) begin
    if (state == ST_COMP) begin
      if (cnt == '0) begin
        work <= {hash_words[0], hash_words[1], hash_words[2], hash_words[3],
                 hash_words[4], hash_words[5], hash_words[6], hash_words[7]};
      end else if (cnt != CNT_DONE) begin
        work <= work_next;
        for (int i = 0; i < BLK_WORDS - 1; i++) begin
          w_sr[i] <= w_sr[i+1];
        end
        w_sr[BLK_WORDS-1] <= wt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_input_while_output: assert property (
    @(posedge clk) disable iff (rst) out_valid |-> in_stall
  ) else $error("input accepted while digest beats are pending");

  a_no_write_in_comp: assert property (
    @(posedge clk) disable iff (rst) (state == ST_COMP) |-> !ram_we
  ) else $error("block buffer written during compression");

  a_full_block_compresses: assert property (
    @(posedge clk) disable iff (rst) (in_fire && blk_full) |=> (state == ST_COMP)
  ) else $error("full block did not start a compression");

  a_restart_after_digest: assert property (
    @(posedge clk) disable iff (rst)
      (out_fire && last_word) |=> (bit_count == '0) && (state == ST_IDLE)
  ) else $error("engine did not restart after the final digest beat");

endmodule

// ===== tb/sv/sha256_digest_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the hash engine, keeps its own SHA-256 state, and
// compares every digest beat with the word it should carry.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          errors,
  output int          words_due
);

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_beat_t;

  localparam logic [31:0] H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0]  hash_state [8];
  logic [7:0]   blk [64];
  logic [63:0]  bit_len;
  digest_beat_t digest_q [$];

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    logic [63:0] twice;
    twice = {v, v} >> n;
    return twice[31:0];
  endfunction

  // Run the 64 rounds over blk and fold the result into hash_state.
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    int i;
    for (i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
    for (i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + KTAB[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
    hash_state[5] += f;
    hash_state[6] += g;
    hash_state[7] += h;
  endfunction

  // Absorb one input beat; on last, pad, finish and queue the eight words.
  function automatic void absorb_beat(input logic [7:0] b, input logic bp, input logic fin);
    int pos;
    int i;
    if (bp) begin
      pos = bit_len[8:3];
      blk[pos] = b;
      bit_len += 64'd8;
      if (pos == 63) compress_block();
    end
    if (fin) begin
      pos = bit_len[8:3];
      blk[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        for (i = pos; i < 64; i++) blk[i] = 8'h00;
        compress_block();
        pos = 0;
      end
      for (i = pos; i < 56; i++) blk[i] = 8'h00;
      for (i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
      compress_block();
      for (i = 0; i < 8; i++)
        digest_q.push_back('{word: hash_state[i], idx: 3'(i), fin: (i == 7)});
      hash_state = H0;
      bit_len = '0;
    end
  endfunction

  function automatic void check_digest_beat();
    digest_beat_t want;
    if (digest_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected digest beat word=%h index=%0d last_word=%b",
                 $realtime, digest_word, word_index, last_word);
      return;
    end
    want = digest_q.pop_front();
    if (digest_word !== want.word || word_index !== want.idx || last_word !== want.fin) begin
      errors++;
      if (errors <= 10)
        $display("%0t: digest mismatch: expected %h/%0d/%b, got %h/%0d/%b", $realtime,
                 want.word, want.idx, want.fin, digest_word, word_index, last_word);
    end
  endfunction

  initial begin
    errors    = 0;
    words_due = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      hash_state = H0;
      bit_len    = '0;
      digest_q.delete();
    end else begin
      if (in_valid && !in_stall) absorb_beat(data_byte, byte_present, last);
      if (out_valid && !out_stall) check_digest_beat();
    end
    words_due = digest_q.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte streams of assorted lengths into the SHA-256 engine, with random gaps
// on the input and random stalls on the digest side; the checker beside the
// engine predicts every digest word and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;

  // Message lengths around the padding boundaries: one or two final blocks,
  // full blocks, and block plus one.
  localparam int EDGE_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
  localparam int ITEM_TARGET   = 410;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic [7:0]  data_byte    = 8'h00;
  logic        byte_present = 1'b0;
  logic        last         = 1'b0;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  int errors;
  int words_due;
  int beats_sent = 0;    // beats that carry a byte or a last
  bit tx_burst   = 1'b0; // no input gaps for the current message
  int rx_calm    = 0;    // digest beats left to take without stall

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sha256_hash_engine i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

  sha256_digest_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word),
    .errors       (errors),
    .words_due    (words_due)
  );

  // Drive one beat: idle for a random gap unless the message is a burst, present
  // the beat at a falling edge, then hold it until a rising edge sees the stall low.
  task automatic send_beat(input logic [7:0] b, input logic bp, input logic fin);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    data_byte    <= b;
    byte_present <= bp;
    last         <= fin;
    do @(posedge clk); while (in_stall);
    if (bp || fin) beats_sent++;
  endtask

  // Drop valid and hold off until every predicted digest word has arrived.
  task automatic drain_digests();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  // One message of len bytes; the end comes either on the final byte or as
  // a separate beat with no byte. Sprinkle in beats that carry nothing.
  task automatic send_message(input int len, input bit sep_last);
    int k;
    int r;
    logic [7:0] b;
    tx_burst = ($urandom_range(0, 3) == 0);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 19) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      r = $urandom_range(0, 9);
      b = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom_range(0, 255));
      send_beat(b, 1'b1, !sep_last && (k == len - 1));
    end
    if (sep_last || len == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Digest side: per beat, hold a random stall once the beat is up, with
  // runs of stall-free beats now and then.
  initial begin
    int n;
    forever begin
      if (rx_calm > 0) begin
        n = 0;
        rx_calm--;
      end else begin
        n = $urandom_range(0, 12);
        if ($urandom_range(0, 7) == 0) rx_calm = $urandom_range(8, 24);
      end
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (n - 1) @(posedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus and verdict.
  initial begin
    int sel;
    int len;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty message: last with no byte.
    send_beat(8'h00, 1'b0, 1'b1);
    // Beat with neither byte nor last: must change nothing.
    send_beat(8'ha5, 1'b0, 1'b0);
    // "abc", last riding on the final byte.
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    // Extreme bytes, an empty beat in between, then a separate last.
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h5a, 1'b0, 1'b1);
    // Single byte equal to the pad marker.
    send_beat(8'h80, 1'b1, 1'b1);
    drain_digests();

    // Random messages: mostly short, a good share right at block boundaries.
    // The 2^64 bit count wrap is out of reach in simulation.
    while (beats_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) len = $urandom_range(0, 10);
      else if (sel < 8) len = EDGE_LENS[$urandom_range(0, 7)];
      else len = $urandom_range(0, 140);
      send_message(len, $urandom_range(0, 1));
      if ($urandom_range(0, 5) == 0) drain_digests();
    end

    drain_digests();
    // Quiet tail to catch any stray digest beat.
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
